/* hw/rtl/cae_pkg.sv */
`timescale 1ns / 1ps

package cae_pkg;

  localparam int VAL_W  = 16;
  localparam int BYTE_W = 8;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_TINFO = 2'd2;
  localparam logic [1:0] STAT_DIV0  = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] tmpl_byte;
    logic              start_req;
    logic              final_byte;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
  } item_t;

  typedef struct packed {
    logic              req;
    logic [BYTE_W-1:0] out_byte;
    logic              done_res;
    logic [1:0]        status;
  } emit_t;

  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  dividend;
    logic [BYTE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [VAL_W-1:0]  quot;
    logic [VAL_W-1:0]  rem;
  } div_rsp_t;

endpackage

/* hw/rtl/cae_chan_if.sv */
`timescale 1ns / 1ps

interface cae_tmpl_if;
  logic                         valid;
  logic                         ready;
  logic [cae_pkg::BYTE_W-1:0]   tmpl_byte;
  logic                         start_req;
  logic                         final_byte;
  logic [cae_pkg::BYTE_W-1:0]   col;
  logic [cae_pkg::BYTE_W-1:0]   row;

  modport source (output valid, tmpl_byte, start_req, final_byte, col, row, input ready);
  modport sink   (input valid, tmpl_byte, start_req, final_byte, col, row, output ready);
endinterface

interface cae_res_if;
  logic                         valid;
  logic                         ready;
  logic [cae_pkg::BYTE_W-1:0]   out_byte;
  logic                         done_res;
  logic [1:0]                   status;

  modport source (output valid, out_byte, done_res, status, input ready);
  modport sink   (input valid, out_byte, done_res, status, output ready);
endinterface

/* hw/rtl/cae_div.sv */
`timescale 1ns / 1ps

// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// Quotient and remainder truncate toward zero; they hold until the next start.
module cae_div (
  input  logic              clk,
  input  logic              rst,
  input  cae_pkg::div_req_t req,
  output cae_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(cae_pkg::VAL_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [cae_pkg::VAL_W-1:0]     acc;
  logic [cae_pkg::BYTE_W-1:0]    part;
  logic [cae_pkg::BYTE_W-1:0]    dvsr;
  logic                          neg;

  logic [cae_pkg::BYTE_W:0]      part_sh;
  logic [cae_pkg::BYTE_W+1:0]    diff;
  logic [cae_pkg::VAL_W-1:0]     mag;

  assign mag     = req.dividend[cae_pkg::VAL_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign part_sh = {part, acc[cae_pkg::VAL_W-1]};
  assign diff    = {1'b0, part_sh} - {2'b00, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      acc  <= mag;
      part <= '0;
      dvsr <= req.divisor;
      neg  <= req.dividend[cae_pkg::VAL_W-1];
    end else if (busy) begin
      // subtract when the shifted partial remainder covers the divisor
      if (!diff[cae_pkg::BYTE_W+1]) begin
        part <= diff[cae_pkg::BYTE_W-1:0];
        acc  <= {acc[cae_pkg::VAL_W-2:0], 1'b1};
      end else begin
        part <= part_sh[cae_pkg::BYTE_W-1:0];
        acc  <= {acc[cae_pkg::VAL_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(cae_pkg::VAL_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  logic [cae_pkg::VAL_W-1:0] rem_mag;
  assign rem_mag = {{(cae_pkg::VAL_W-cae_pkg::BYTE_W){1'b0}}, part};

  always_comb begin
    rsp.busy = busy;
    rsp.quot = neg ? (~acc + 1'b1) : acc;
    rsp.rem  = neg ? (~rem_mag + 1'b1) : rem_mag;
  end

endmodule

/* hw/rtl/cae_seq.sv */
`timescale 1ns / 1ps

// Template parser and escape sequencer. Holds the cursor state, issues
// divides to the shared divider and hands results out one per cycle while the output register is free.
module cae_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  cae_pkg::item_t    item,
  output logic              in_ready,
  input  logic              out_free,
  output cae_pkg::emit_t    emit,
  output cae_pkg::div_req_t div_req,
  input  cae_pkg::div_rsp_t div_rsp
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_DIV  = 6'b000100,
    S_POST = 6'b001000,
    S_LAST = 6'b010000,
    S_TERM = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PM_PLAIN = 3'd0,
    PM_ESC   = 3'd1,
    PM_PLUS  = 3'd2,
    PM_GT1   = 3'd3,
    PM_GT2   = 3'd4,
    PM_DIV   = 3'd5
  } pm_t;

  typedef enum logic [2:0] {
    OP_R1,     // print remainder digit only
    OP_2,      // print quotient digit, then remainder digit
    OP_3,      // hundreds, then fall into OP_2 on the remainder
    OP_BCD,
    OP_DELTA,
    OP_SLASH
  } op_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UD    = 8'h44;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_UP    = 8'h50;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_BRACE = 8'h7B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] DIV_TEN  = 8'd10;
  localparam logic [7:0] DIV_HUND = 8'd100;
  localparam logic [7:0] DIV_SIXT = 8'd16;
  localparam logic [15:0] NFLIP   = 16'h0060;

  function automatic logic [7:0] dig(input logic [15:0] v);
    dig = v[7:0] | CH_ZERO;
  endfunction

  state_t        state, state_next;
  op_t           op, op_next;
  pm_t           pm, pm_next;
  logic [7:0]    tb, tb_next;
  logic          last_q, last_next;
  logic [15:0]   cur_col, cur_col_next;
  logic [15:0]   cur_line, cur_line_next;
  logic [15:0]   wv, wv_next;
  logic          on_column, on_column_next;
  logic [7:0]    gt, gt_next;
  logic          err, err_next;
  logic          stall;
  logic [15:0]   sum_b;
  logic [15:0]   toggled;

  assign sum_b   = wv + {8'h00, tb};
  assign toggled = on_column ? cur_line : cur_col;
  assign stall   = emit.req && !out_free;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    op_next        = op;
    pm_next        = pm;
    tb_next        = tb;
    last_next      = last_q;
    cur_col_next   = cur_col;
    cur_line_next  = cur_line;
    wv_next        = wv;
    on_column_next = on_column;
    gt_next        = gt;
    err_next       = err;
    emit           = '0;
    emit.status    = cae_pkg::STAT_OK;
    div_req        = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          tb_next    = item.tmpl_byte;
          last_next  = item.final_byte;
          if (item.start_req) begin
            cur_col_next   = {8'h00, item.col};
            cur_line_next  = {8'h00, item.row};
            on_column_next = 1'b0;
            wv_next        = {8'h00, item.row};
            pm_next        = PM_PLAIN;
            gt_next        = '0;
            err_next       = 1'b0;
          end
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_LAST;
        if (!err) begin
          case (pm)
            PM_ESC: begin
              pm_next = PM_PLAIN;
              case (tb) inside
                CH_D: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = wv;
                  state_next       = S_DIV;
                  if ($signed(wv) < 16'sd10) begin
                    op_next         = OP_R1;
                    div_req.divisor = DIV_TEN;
                  end else if ($signed(wv) < 16'sd100) begin
                    op_next         = OP_2;
                    div_req.divisor = DIV_TEN;
                  end else begin
                    op_next         = OP_3;
                    div_req.divisor = DIV_HUND;
                  end
                end
                CH_3: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = wv;
                  div_req.divisor  = DIV_HUND;
                  op_next          = OP_3;
                  state_next       = S_DIV;
                end
                CH_2: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = wv;
                  div_req.divisor  = DIV_TEN;
                  op_next          = OP_2;
                  state_next       = S_DIV;
                end
                CH_UB: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = wv;
                  div_req.divisor  = DIV_TEN;
                  op_next          = OP_BCD;
                  state_next       = S_DIV;
                end
                CH_UD: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = wv;
                  div_req.divisor  = DIV_SIXT;
                  op_next          = OP_DELTA;
                  state_next       = S_DIV;
                end
                CH_DOT: begin
                  emit.req       = 1'b1;
                  emit.out_byte  = wv[7:0];
                  on_column_next = !on_column;
                  wv_next        = toggled;
                end
                CH_PLUS:  pm_next = PM_PLUS;
                CH_GT:    pm_next = PM_GT1;
                CH_SLASH: pm_next = PM_DIV;
                CH_N: begin
                  cur_col_next  = cur_col ^ NFLIP;
                  cur_line_next = cur_line ^ NFLIP;
                  wv_next       = on_column ? (cur_col ^ NFLIP) : (cur_line ^ NFLIP);
                end
                CH_R: begin
                  on_column_next = 1'b1;
                  wv_next        = cur_col;
                end
                CH_I: begin
                  cur_col_next  = cur_col + 1'b1;
                  cur_line_next = cur_line + 1'b1;
                  wv_next       = wv + 1'b1;
                end
                CH_PCT: begin
                  emit.req      = 1'b1;
                  emit.out_byte = CH_PCT;
                end
                CH_P, CH_UP, CH_QUOTE, CH_BRACE, CH_QMARK: begin
                  emit.req    = 1'b1;
                  emit.status = cae_pkg::STAT_TINFO;
                  err_next    = 1'b1;
                end
                default: begin
                  emit.req    = 1'b1;
                  emit.status = cae_pkg::STAT_BAD;
                  err_next    = 1'b1;
                end
              endcase
            end
            PM_PLUS: begin
              emit.req       = 1'b1;
              emit.out_byte  = sum_b[7:0];
              pm_next        = PM_PLAIN;
              on_column_next = !on_column;
              wv_next        = toggled;
            end
            PM_GT1: begin
              gt_next = tb;
              pm_next = PM_GT2;
            end
            PM_GT2: begin
              if ($signed(wv) > $signed({8'h00, gt})) begin
                wv_next = sum_b;
              end
              pm_next = PM_PLAIN;
            end
            PM_DIV: begin
              if (tb == '0) begin
                emit.req    = 1'b1;
                emit.status = cae_pkg::STAT_DIV0;
                err_next    = 1'b1;
                pm_next     = PM_PLAIN;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = wv;
                div_req.divisor  = tb;
                op_next          = OP_SLASH;
                pm_next          = PM_PLAIN;
                state_next       = S_DIV;
              end
            end
            default: begin
              if (tb == CH_PCT) begin
                pm_next = PM_ESC;
              end else begin
                emit.req      = 1'b1;
                emit.out_byte = tb;
              end
            end
          endcase
        end
      end

      S_DIV: begin
        if (!div_rsp.busy) begin
          case (op)
            OP_R1: begin
              emit.req       = 1'b1;
              emit.out_byte  = dig(div_rsp.rem);
              on_column_next = !on_column;
              wv_next        = toggled;
              state_next     = S_LAST;
            end
            OP_2: begin
              emit.req      = 1'b1;
              emit.out_byte = dig(div_rsp.quot);
              state_next    = S_POST;
            end
            OP_3: begin
              // print hundreds, then split the remainder into tens and units
              emit.req         = 1'b1;
              emit.out_byte    = dig(div_rsp.quot);
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.rem;
              div_req.divisor  = DIV_TEN;
              op_next          = OP_2;
            end
            OP_BCD: begin
              wv_next    = {div_rsp.quot[11:0], 4'h0} + div_rsp.rem;
              state_next = S_LAST;
            end
            OP_DELTA: begin
              wv_next    = wv - {div_rsp.rem[14:0], 1'b0};
              state_next = S_LAST;
            end
            default: begin
              emit.req      = 1'b1;
              emit.out_byte = dig(div_rsp.quot);
              wv_next       = div_rsp.rem;
              state_next    = S_LAST;
            end
          endcase
        end
      end

      S_POST: begin
        emit.req       = 1'b1;
        emit.out_byte  = dig(div_rsp.rem);
        on_column_next = !on_column;
        wv_next        = toggled;
        state_next     = S_LAST;
      end

      S_LAST: begin
        if (!last_q) begin
          state_next = S_IDLE;
        end else if (!err && pm != PM_PLAIN) begin
          // template ended inside an escape
          emit.req    = 1'b1;
          emit.status = cae_pkg::STAT_BAD;
          err_next    = 1'b1;
          pm_next     = PM_PLAIN;
          state_next  = S_TERM;
        end else begin
          emit.req      = 1'b1;
          emit.done_res = 1'b1;
          pm_next       = PM_PLAIN;
          err_next      = 1'b0;
          state_next    = S_IDLE;
        end
      end

      S_TERM: begin
        emit.req      = 1'b1;
        emit.done_res = 1'b1;
        pm_next       = PM_PLAIN;
        err_next      = 1'b0;
        state_next    = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    // hold the divider start while the result cannot be handed out
    if (stall) begin
      div_req.start = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pm        <= PM_PLAIN;
      err       <= 1'b0;
      cur_col   <= '0;
      cur_line  <= '0;
      wv        <= '0;
      on_column <= 1'b0;
      gt        <= '0;
    end else if (!stall) begin
      state     <= state_next;
      pm        <= pm_next;
      err       <= err_next;
      cur_col   <= cur_col_next;
      cur_line  <= cur_line_next;
      wv        <= wv_next;
      on_column <= on_column_next;
      gt        <= gt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      op     <= op_next;
      tb     <= tb_next;
      last_q <= last_next;
    end
  end

endmodule

/* hw/rtl/cursor_address_expander.sv */
`timescale 1ns / 1ps

// Cursor-motion template expander. Feed a cursor-motion template one byte
// per transaction on tmpl_ch; mark its first byte with start_req (column and
// line are taken from that transaction) and its last byte with final_byte.
// Plain bytes come back unchanged on res_ch, percent escapes print or modify
// the current value, and the last byte is followed by a zero byte with
// done_res set. A bad escape, a terminfo-style escape or a divide by zero
// gives one result with a nonzero status and the rest of the template up to
// its last byte is dropped. One byte is taken at a time: a plain byte, a
// dropped byte or a state-only escape passes through the execute and last
// states; %d, %2, %B, %D and the divisor byte of %/ also wait in the divide
// state, and %3 (or %d at 100 and above) runs two divides, on the radix-2
// divider shared by all digit and divide escapes; a last byte that ends inside
// an escape adds a terminator state after its error result. A result also holds the
// sequencer while the single output register is full and not being taken
// downstream.
module cursor_address_expander (
  input  logic           clk,
  input  logic           rst,
  cae_tmpl_if.sink       tmpl_ch,
  cae_res_if.source      res_ch
);

  cae_pkg::item_t    item;
  cae_pkg::emit_t    emit;
  cae_pkg::div_req_t div_req;
  cae_pkg::div_rsp_t div_rsp;
  logic              in_ready;
  logic              accept;
  logic              out_free;

  logic                        out_valid;
  logic [cae_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        done_q;
  logic [1:0]                  status_q;

  // Input side: one template byte per transaction while the sequencer idles.
  assign tmpl_ch.ready = in_ready;
  assign accept        = tmpl_ch.valid && in_ready;

  always_comb begin
    item.tmpl_byte  = tmpl_ch.tmpl_byte;
    item.start_req  = tmpl_ch.start_req;
    item.final_byte = tmpl_ch.final_byte;
    item.col        = tmpl_ch.col;
    item.row        = tmpl_ch.row;
  end

  cae_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .in_ready (in_ready),
    .out_free (out_free),
    .emit     (emit),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  cae_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register: free when empty or being taken this cycle, so the
  // sequencer can load back-to-back results into a draining register.
  assign out_free = !out_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.req && out_free) begin
      out_valid <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.req && out_free) begin
      out_byte_q <= emit.out_byte;
      done_q     <= emit.done_res;
      status_q   <= emit.status;
    end
  end

  assign res_ch.valid    = out_valid;
  assign res_ch.out_byte = out_byte_q;
  assign res_ch.done_res = done_q;
  assign res_ch.status   = status_q;

  // A taken template byte keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tmpl_ch.ready)
    else $error("input accepted on consecutive cycles");

  // The shared divider is never restarted mid-operation.
  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The terminator is a zero byte with a clean status.
  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.done_res) |->
      (res_ch.out_byte == '0 && res_ch.status == cae_pkg::STAT_OK))
    else $error("malformed terminator");

  // Error results carry a zero byte and never close the expansion.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.status != cae_pkg::STAT_OK) |->
      (res_ch.out_byte == '0 && !res_ch.done_res))
    else $error("malformed error result");

endmodule
